@@ sv/erpe_pkg.sv @@
// Package for the rule predicate evaluator: sizes, operation and compare
// codes, predicate layout, and the controller/datapath command and status types.
// No dependencies.
package erpe_pkg;

  // Table sizes
  localparam int unsigned NumRules   = 16;
  localparam int unsigned MaxPreds   = 4;
  localparam int unsigned NumInputs  = 16;

  // Field widths fixed by the item layout
  localparam int unsigned OpW        = 2;
  localparam int unsigned IdxW       = 4;
  localparam int unsigned SlotW      = 2;
  localparam int unsigned KindW      = 2;
  localparam int unsigned ValW       = 32;
  localparam int unsigned CntW       = 3;
  localparam int unsigned MaskW      = 16;

  // Predicate table depth and address width
  localparam int unsigned PredDepth  = NumRules * MaxPreds;
  localparam int unsigned PredAddrW  = $clog2(PredDepth);
  localparam int unsigned RuleW      = $clog2(NumRules);

  // Item operations
  typedef enum logic [OpW-1:0] {
    OP_SET_INPUT  = 2'd0,
    OP_WRITE_PRED = 2'd1,
    OP_SET_COUNT  = 2'd2,
    OP_EVALUATE   = 2'd3
  } op_e;

  // Comparison kinds
  typedef enum logic [KindW-1:0] {
    CMP_EQ   = 2'd0,
    CMP_GT   = 2'd1,
    CMP_LT   = 2'd2,
    CMP_NONE = 2'd3
  } cmp_e;

  // One stored predicate
  typedef struct packed {
    logic [IdxW-1:0]        src;
    logic [KindW-1:0]       kind;
    logic signed [ValW-1:0] constant;
  } pred_t;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_WALK  = 2'd1,
    ST_FLUSH = 2'd2,
    ST_HOLD  = 2'd3
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic write_en;   // apply a table write for the accepted word
    logic start;      // open an evaluation walk
    logic walk;       // read the next predicate entry
    logic load_out;   // move the finished mask into the output register
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic last_addr;  // walk pointer sits on the final entry
    logic out_busy;   // output register holds a word that is not taken
  } dp_stat_t;

endpackage

@@ sv/erpe_ctrl.sv @@
// Controller of the rule predicate evaluator: input handshake and the
// evaluation walk sequencer. Depends on erpe_pkg.
module erpe_ctrl (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  logic [erpe_pkg::OpW-1:0]  operation_i,
  output logic                      in_ready_o,
  input  erpe_pkg::dp_stat_t        stat_i,
  output erpe_pkg::ctrl_cmd_t       cmd_o
);

  erpe_pkg::state_e state_q, state_d;
  logic             accept;
  logic             is_eval;

  assign in_ready_o = (state_q == erpe_pkg::ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign is_eval    = (operation_i == erpe_pkg::OP_EVALUATE);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      erpe_pkg::ST_IDLE: begin
        if (accept && is_eval) state_d = erpe_pkg::ST_WALK;
      end
      erpe_pkg::ST_WALK: begin
        if (stat_i.last_addr) state_d = erpe_pkg::ST_FLUSH;
      end
      erpe_pkg::ST_FLUSH: begin
        state_d = erpe_pkg::ST_HOLD;
      end
      erpe_pkg::ST_HOLD: begin
        if (!stat_i.out_busy) state_d = erpe_pkg::ST_IDLE;
      end
      default: begin
        state_d = erpe_pkg::ST_IDLE;
      end
    endcase
  end

  // Commands
  always_comb begin
    cmd_o = '0;
    case (state_q)
      erpe_pkg::ST_IDLE: begin
        cmd_o.write_en = accept && !is_eval;
        cmd_o.start    = accept && is_eval;
      end
      erpe_pkg::ST_WALK: begin
        cmd_o.walk = 1'b1;
      end
      erpe_pkg::ST_HOLD: begin
        cmd_o.load_out = !stat_i.out_busy;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= erpe_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ sv/erpe_dpath.sv @@
// Datapath of the rule predicate evaluator: input values, rule counts,
// predicate memory, compare stage, fired mask and output register. Depends on erpe_pkg.
module erpe_dpath (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic [erpe_pkg::OpW-1:0]         operation_i,
  input  logic [erpe_pkg::IdxW-1:0]        target_index_i,
  input  logic [erpe_pkg::SlotW-1:0]       slot_i,
  input  logic [erpe_pkg::IdxW-1:0]        source_input_i,
  input  logic [erpe_pkg::KindW-1:0]       compare_kind_i,
  input  logic signed [erpe_pkg::ValW-1:0] operand_value_i,
  input  logic [erpe_pkg::CntW-1:0]        predicate_count_i,
  input  erpe_pkg::ctrl_cmd_t              cmd_i,
  output erpe_pkg::dp_stat_t               stat_o,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [erpe_pkg::MaskW-1:0]       fired_mask_o
);

  logic signed [erpe_pkg::ValW-1:0] in_vals_q [erpe_pkg::NumInputs];
  logic [erpe_pkg::CntW-1:0]        counts_q  [erpe_pkg::NumRules];
  erpe_pkg::pred_t                  pred_mem  [erpe_pkg::PredDepth];

  logic [erpe_pkg::PredAddrW-1:0]   addr_q;
  erpe_pkg::pred_t                  rd_q;
  logic [erpe_pkg::PredAddrW-1:0]   tag_q;
  logic                             tag_vld_q;
  logic [erpe_pkg::MaskW-1:0]       mask_q;
  logic [erpe_pkg::MaskW-1:0]       fired_q;
  logic                             out_valid_q;

  logic [erpe_pkg::PredAddrW-1:0]   wr_addr;
  logic [erpe_pkg::CntW-1:0]        cnt_sat;
  logic [erpe_pkg::RuleW-1:0]       tag_rule;
  logic [erpe_pkg::SlotW-1:0]       tag_slot;
  logic signed [erpe_pkg::ValW-1:0] src_val;
  logic                             holds;
  logic                             active;
  logic                             tgt_input_ok;
  logic                             tgt_rule_ok;
  logic                             slot_ok;

  assign wr_addr  = erpe_pkg::PredAddrW'({target_index_i, slot_i});
  assign tgt_input_ok = (32'(target_index_i) < erpe_pkg::NumInputs);
  assign tgt_rule_ok  = (32'(target_index_i) < erpe_pkg::NumRules);
  assign slot_ok      = (32'(slot_i) < erpe_pkg::MaxPreds);
  assign cnt_sat  = (32'(predicate_count_i) > erpe_pkg::MaxPreds)
                  ? erpe_pkg::CntW'(erpe_pkg::MaxPreds) : predicate_count_i;

  // Status toward the controller
  assign stat_o.last_addr = (addr_q == erpe_pkg::PredAddrW'(erpe_pkg::PredDepth - 1));
  assign stat_o.out_busy  = out_valid_q && !out_ready_i;

  // Compare stage on the registered predicate
  assign tag_rule = tag_q[erpe_pkg::PredAddrW-1:erpe_pkg::SlotW];
  assign tag_slot = tag_q[erpe_pkg::SlotW-1:0];
  assign src_val  = (32'(rd_q.src) < erpe_pkg::NumInputs) ? in_vals_q[rd_q.src] : '0;
  assign active   = ({1'b0, tag_slot} < counts_q[tag_rule]);

  always_comb begin
    case (rd_q.kind)
      erpe_pkg::CMP_EQ: holds = (src_val == rd_q.constant);
      erpe_pkg::CMP_GT: holds = (src_val >  rd_q.constant);
      erpe_pkg::CMP_LT: holds = (src_val <  rd_q.constant);
      default:          holds = 1'b1;
    endcase
  end

  // Input values and rule counts
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < erpe_pkg::NumInputs; i++) in_vals_q[i] <= '0;
      for (int r = 0; r < erpe_pkg::NumRules; r++) counts_q[r] <= '0;
    end else if (cmd_i.write_en) begin
      if (operation_i == erpe_pkg::OP_SET_INPUT && tgt_input_ok) begin
        in_vals_q[target_index_i] <= operand_value_i;
      end
      if (operation_i == erpe_pkg::OP_SET_COUNT && tgt_rule_ok) begin
        counts_q[target_index_i] <= cnt_sat;
      end
    end
  end

  // Predicate memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.write_en && operation_i == erpe_pkg::OP_WRITE_PRED && tgt_rule_ok && slot_ok) begin
      pred_mem[wr_addr] <= '{src: source_input_i, kind: compare_kind_i,
                             constant: operand_value_i};
    end
    if (cmd_i.walk) begin
      rd_q <= pred_mem[addr_q];
    end
  end

  // Advance the walk pointer and tag the entry in flight
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q    <= '0;
      tag_q     <= '0;
      tag_vld_q <= 1'b0;
    end else begin
      tag_vld_q <= cmd_i.walk;
      if (cmd_i.start) begin
        addr_q <= '0;
      end else if (cmd_i.walk) begin
        addr_q <= addr_q + 1'b1;
        tag_q  <= addr_q;
      end
    end
  end

  // Seed the mask with nonzero counts, drop rules with a failing predicate
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0;
    end else if (cmd_i.start) begin
      for (int r = 0; r < erpe_pkg::MaskW; r++) begin
        mask_q[r] <= (r < erpe_pkg::NumRules) ? (counts_q[r] != '0) : 1'b0;
      end
    end else if (tag_vld_q && active && !holds) begin
      mask_q[tag_rule] <= 1'b0;
    end
  end

  // Output word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) fired_q <= mask_q;
  end

  assign out_valid_o  = out_valid_q;
  assign fired_mask_o = fired_q;

endmodule

@@ sv/eca_rule_predicate_evaluator.sv @@
// Top level of the rule predicate evaluator: controller plus datapath.
// Depends on erpe_pkg, erpe_ctrl and erpe_dpath.
//
//   channel | handshake              | word
//   --------+------------------------+-------------------------------------------
//   in      | in_valid_i / in_ready_o | operation, target_index, slot, source_input,
//           |                        | compare_kind, operand_value, predicate_count
//   out     | out_valid_o/out_ready_i | fired_mask
//
// Table writes leave the controller idle and ready for the next word. Evaluate walks
// all 64 predicate entries, one memory read and one 32-bit compare per cycle; a
// flush state then lets the last compare land, and a hold state loads the result
// word once the output register is free or its word is taken. Input is refused
// during the walk, the flush and while a finished mask waits for the output register
// to free. Reset clears input values and rule counts; the predicate memory is not cleared.
module eca_rule_predicate_evaluator (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [erpe_pkg::OpW-1:0]         operation_i,
  input  logic [erpe_pkg::IdxW-1:0]        target_index_i,
  input  logic [erpe_pkg::SlotW-1:0]       slot_i,
  input  logic [erpe_pkg::IdxW-1:0]        source_input_i,
  input  logic [erpe_pkg::KindW-1:0]       compare_kind_i,
  input  logic signed [erpe_pkg::ValW-1:0] operand_value_i,
  input  logic [erpe_pkg::CntW-1:0]        predicate_count_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [erpe_pkg::MaskW-1:0]       fired_mask_o
);

  erpe_pkg::ctrl_cmd_t cmd;
  erpe_pkg::dp_stat_t  stat;

  erpe_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .operation_i (operation_i),
    .in_ready_o  (in_ready_o),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  erpe_dpath u_dpath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .operation_i       (operation_i),
    .target_index_i    (target_index_i),
    .slot_i            (slot_i),
    .source_input_i    (source_input_i),
    .compare_kind_i    (compare_kind_i),
    .operand_value_i   (operand_value_i),
    .predicate_count_i (predicate_count_i),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .fired_mask_o      (fired_mask_o)
  );

endmodule
